[design/efd_pkg.sv]
// Package: types, constants and codes of the equal-frequency discretizer.
`default_nettype none
package efd_pkg;

  localparam int unsigned MaxValuesDef = 256;
  localparam int unsigned MaxBandsDef  = 16;
  localparam int unsigned DivW         = 13;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_LOAD     = 2'd1,
    OP_FINISH   = 2'd2,
    OP_CLASSIFY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_NOVALUES = 3'd3,
    ST_DROPPED  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_GRANULARITY   = 1'd0,
    CFG_DISTINCT_ONLY = 1'd1
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_CMP,     // compare entry i with the new word
    S_LD_SHIFT,   // ripple the carried word upward
    S_FN_CNT,     // count value changes
    S_FN_DIV,
    S_FN_LO_RD,
    S_FN_LO_WT,
    S_FN_HI,
    S_FN_STEP,
    S_CL_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic        value_unknown;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  band_index;
    logic [31:0] band_min;
    logic [31:0] band_max;
    logic [2:0]  status;
    logic        last;
  } out_word_t;

  // Divider request and reply between the controller and the divider.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[design/equal_frequency_discretizer_top.sv]
// Top level: configuration registers, controller and divider.
// Load walks the sorted store; clear and immediate answers do not raise busy; classify scans
// bands in order. Finish counts value changes, divides for the step, then reads each band,
// skipping words equal to its lower bound and dividing again after each band that skipped.
// One item at a time: the next is taken the cycle busy falls. Results are registered.
// Results cannot be stalled. Reset empties the store, drops bands, granularity 4, distinct 0.
`default_nettype none
module equal_frequency_discretizer_top #(
  parameter int unsigned MAX_VALUES = efd_pkg::MaxValuesDef,
  parameter int unsigned MAX_BANDS  = efd_pkg::MaxBandsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  efd_pkg::in_word_t   in_i,
  output efd_pkg::out_word_t  res_o,
  output logic                res_valid_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire                 cfg_index_i,
  input  wire  [4:0]          cfg_data_i
);
  import efd_pkg::*;

  logic [4:0] gran_q;
  logic       dist_q;
  div_req_t   dreq;
  div_rsp_t   drsp;

  // Take configuration only while no item is in flight
  assign cfg_ready_o = !busy;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gran_q <= 5'd4;
      dist_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_e'(cfg_index_i) == CFG_GRANULARITY) gran_q <= cfg_data_i;
      else dist_q <= cfg_data_i[0];
    end
  end

  efd_ctrl #(.MAX_VALUES(MAX_VALUES), .MAX_BANDS(MAX_BANDS)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .in_i, .busy_o(busy),
    .granularity_i(gran_q), .distinct_only_i(dist_q),
    .res_o, .res_valid_o, .div_req_o(dreq), .div_rsp_i(drsp)
  );

  efd_div #(.W(DivW)) u_div (
    .clk_i, .rst_ni, .start_i(dreq.start), .dividend_i(dreq.dividend),
    .divisor_i(dreq.divisor), .done_o(drsp.done), .quotient_o(drsp.quotient)
  );

endmodule
`default_nettype wire

[design/efd_div.sv]
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module efd_div #(
  parameter int unsigned W = 13
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire  [W-1:0]       dividend_i,
  input  wire  [W-1:0]       divisor_i,
  output logic               done_o,
  output logic [W-1:0]       quotient_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    trial;

  // Shift one bit in and subtract where it fits
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[W-1:0], quo_q[W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = busy_q && (cnt_q == CW'(1));
  assign quotient_o = quo_d;

  // The counter only runs while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_q |-> !done_o)
    else $error("divider done while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_q || $past(start_i))
    else $error("divider busy after done");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not start");

endmodule
`default_nettype wire

[design/efd_ctrl.sv]
// Controller: sorted value memory, band memories and the sequencer.
`default_nettype none
module efd_ctrl #(
  parameter int unsigned MAX_VALUES = efd_pkg::MaxValuesDef,
  parameter int unsigned MAX_BANDS  = efd_pkg::MaxBandsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  efd_pkg::in_word_t   in_i,
  output logic                busy_o,
  input  wire  [4:0]          granularity_i,
  input  wire                 distinct_only_i,
  output efd_pkg::out_word_t  res_o,
  output logic                res_valid_o,
  output efd_pkg::div_req_t   div_req_o,
  input  efd_pkg::div_rsp_t   div_rsp_i
);
  import efd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VALUES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

  // Value store and band stores
  logic [31:0] mem_v [MAX_VALUES];
  logic [31:0] mem_lo [MAX_BANDS];
  logic [31:0] mem_hi [MAX_BANDS];
  logic [AW-1:0] v_raddr, v_waddr;
  logic          v_we;
  logic [31:0]   v_wdata, v_rdata_q;
  logic [BW-1:0] b_raddr, b_waddr;
  logic          b_we;
  logic [31:0]   b_lo_w, b_hi_w, lo_rdata_q, hi_rdata_q;

  always_ff @(posedge clk_i) begin
    if (v_we) mem_v[v_waddr] <= v_wdata;
    v_rdata_q <= mem_v[v_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      mem_lo[b_waddr] <= b_lo_w;
      mem_hi[b_waddr] <= b_hi_w;
    end
    lo_rdata_q <= mem_lo[b_raddr];
    hi_rdata_q <= mem_hi[b_raddr];
  end

  state_e        st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;     // value_count
  logic [CW-1:0] i_q, i_d;         // walk index
  logic [CW-1:0] k_q, k_d;         // boundary index
  logic [CW-1:0] chg_q, chg_d;     // distinct changes
  logic [CW-1:0] step_q, step_d;
  logic [BW-1:0] j_q, j_d;
  logic [BW-1:0] top_q, top_d;     // top_band
  logic [BW-1:0] ftop_q, ftop_d;   // top while finishing
  logic          ovf_q, ovf_d, rdy_q, rdy_d;
  logic          skip_q, skip_d;   // band skipped equal words
  logic [31:0]   val_q, val_d;     // item value / carried word
  logic [31:0]   lo_q, lo_d, prev_q, prev_d;
  logic [31:0]   b0lo_q, b0lo_d;
  logic          rv_d, rv_q;
  out_word_t     res_d, res_q;
  logic [CW-1:0] last_idx;
  logic [CW:0]   ksum;
  logic [4:0]    cap;
  logic [BW:0]   capm1;

  assign last_idx = cnt_q - 1'b1;
  assign ksum     = {1'b0, k_q} + {1'b0, step_q};

  always_comb begin
    cap = (granularity_i == 5'd0) ? 5'd1 : granularity_i;
    if (32'(cap) > MAX_BANDS) capm1 = (BW+1)'(MAX_BANDS - 1);
    else capm1 = (BW+1)'(cap - 5'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      top_q <= '0;
      ovf_q <= 1'b0;
      rdy_q <= 1'b0;
      rv_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      top_q <= top_d;
      ovf_q <= ovf_d;
      rdy_q <= rdy_d;
      rv_q  <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; k_q <= k_d; chg_q <= chg_d; step_q <= step_d;
    j_q <= j_d; ftop_q <= ftop_d; val_q <= val_d; lo_q <= lo_d;
    prev_q <= prev_d; b0lo_q <= b0lo_d; res_q <= res_d; skip_q <= skip_d;
  end

  // Sequence load, finish and classify through the memories
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; top_d = top_q; ovf_d = ovf_q; rdy_d = rdy_q;
    i_d = i_q; k_d = k_q; chg_d = chg_q; step_d = step_q; j_d = j_q;
    ftop_d = ftop_q; skip_d = skip_q; val_d = val_q; lo_d = lo_q; prev_d = prev_q;
    b0lo_d = b0lo_q;
    rv_d = 1'b0; res_d = res_q;
    v_raddr = i_q[AW-1:0]; v_waddr = i_q[AW-1:0]; v_we = 1'b0; v_wdata = val_q;
    b_raddr = j_q; b_waddr = j_q; b_we = 1'b0; b_lo_w = lo_q; b_hi_w = v_rdata_q;
    div_req_o = '0;
    unique case (st_q)
      S_IDLE: begin
        if (start_i) begin
          val_d = in_i.value;
          i_d = '0; j_d = '0; chg_d = '0;
          v_raddr = '0; b_raddr = '0;
          unique case (op_e'(in_i.op))
            OP_CLEAR: begin
              cnt_d = '0; ovf_d = 1'b0; rdy_d = 1'b0; top_d = '0;
            end
            OP_LOAD: begin
              if (!in_i.value_unknown) st_d = S_LD_CMP;
            end
            OP_FINISH: begin
              if (cnt_q == '0) begin
                rdy_d = 1'b0; rv_d = 1'b1;
                res_d = '{kind: 1'b0, band_index: 4'd0, band_min: '0, band_max: '0,
                          status: ST_NOVALUES, last: 1'b1};
              end else begin
                st_d = S_FN_CNT;
              end
            end
            OP_CLASSIFY: begin
              if (in_i.value_unknown || !rdy_q) begin
                rv_d = 1'b1;
                res_d = '{kind: 1'b1, band_index: 4'd0, band_min: '0, band_max: '0,
                          status: in_i.value_unknown ? ST_UNKNOWN : ST_NOVALUES,
                          last: 1'b1};
              end else begin
                st_d = S_CL_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      // Load: scan for a duplicate (when distinct only) or the first entry above the word
      S_LD_CMP: begin
        if (i_q == cnt_q) begin
          // append at the end, or drop when full
          if (cnt_q == CW'(MAX_VALUES)) ovf_d = 1'b1;
          else begin
            v_we = 1'b1; cnt_d = cnt_q + 1'b1;
          end
          st_d = S_IDLE;
        end else if (distinct_only_i && v_rdata_q == val_q) begin
          st_d = S_IDLE;
        end else if ($signed(v_rdata_q) > $signed(val_q)) begin
          if (cnt_q == CW'(MAX_VALUES)) begin
            ovf_d = 1'b1; st_d = S_IDLE;
          end else begin
            // write the word here and carry the old entry upward
            v_we = 1'b1; val_d = v_rdata_q; i_d = i_q + 1'b1;
            v_raddr = i_d[AW-1:0]; st_d = S_LD_SHIFT;
          end
        end else begin
          i_d = i_q + 1'b1;
          v_raddr = i_d[AW-1:0];
        end
      end
      // Ripple: write the carried word, take the old entry
      S_LD_SHIFT: begin
        v_we = 1'b1;
        if (i_q == cnt_q) begin
          cnt_d = cnt_q + 1'b1; st_d = S_IDLE;
        end else begin
          val_d = v_rdata_q; i_d = i_q + 1'b1; v_raddr = i_d[AW-1:0];
        end
      end
      // Finish: count value changes, then divide for the step
      S_FN_CNT: begin
        if (i_q != '0 && v_rdata_q != prev_q) chg_d = chg_q + 1'b1;
        prev_d = v_rdata_q;
        if (i_q == last_idx) begin
          ftop_d = (chg_d < CW'(capm1)) ? BW'(chg_d) : BW'(capm1);
          div_req_o.start = 1'b1;
          div_req_o.dividend = DivW'(cnt_q);
          div_req_o.divisor = DivW'(ftop_d) + DivW'(1);
          st_d = S_FN_DIV;
        end else begin
          i_d = i_q + 1'b1; v_raddr = i_d[AW-1:0];
        end
      end
      S_FN_DIV: begin
        if (div_rsp_i.done) begin
          step_d = CW'(div_rsp_i.quotient);
          k_d = '0; j_d = '0; st_d = S_FN_LO_RD;
        end
      end
      S_FN_LO_RD: begin
        v_raddr = k_q[AW-1:0]; st_d = S_FN_LO_WT;
      end
      S_FN_LO_WT: begin
        lo_d = v_rdata_q; skip_d = 1'b0;
        if (j_q == ftop_q) begin
          v_raddr = last_idx[AW-1:0];
        end else begin
          // advance by the step, saturating at the last word
          k_d = (ksum > {1'b0, last_idx}) ? last_idx : ksum[CW-1:0];
          v_raddr = k_d[AW-1:0];
        end
        st_d = S_FN_HI;
      end
      S_FN_HI: begin
        if (j_q != ftop_q && v_rdata_q == lo_q && k_q < last_idx) begin
          // skip a run of words equal to the lower bound
          k_d = k_q + 1'b1; v_raddr = k_d[AW-1:0]; skip_d = 1'b1;
        end else begin
          b_we = 1'b1;
          if (j_q == '0) b0lo_d = lo_q;
          rv_d = 1'b1;
          res_d = '{kind: 1'b0, band_index: 4'(j_q), band_min: lo_q, band_max: v_rdata_q,
                    status: ovf_q ? ST_DROPPED : ST_OK, last: j_q == ftop_q};
          if (j_q == ftop_q) begin
            top_d = ftop_q; rdy_d = 1'b1; st_d = S_IDLE;
          end else if (skip_q) begin
            // recompute the step from the words left
            div_req_o.start = 1'b1;
            div_req_o.dividend = DivW'(cnt_q - k_q);
            div_req_o.divisor = DivW'(ftop_q - j_q);
            st_d = S_FN_STEP;
          end else begin
            j_d = j_q + 1'b1; st_d = S_FN_LO_RD;
          end
        end
      end
      S_FN_STEP: begin
        if (div_rsp_i.done) begin
          step_d = CW'(div_rsp_i.quotient);
          j_d = j_q + 1'b1; st_d = S_FN_LO_RD;
        end
      end
      // Classify: scan bands in order
      S_CL_SCAN: begin
        if ($signed(val_q) >= $signed(lo_rdata_q) &&
            ((j_q == top_q) ? ($signed(val_q) <= $signed(hi_rdata_q))
                            : ($signed(val_q) <  $signed(hi_rdata_q)))) begin
          rv_d = 1'b1; st_d = S_IDLE;
          res_d = '{kind: 1'b1, band_index: 4'(j_q), band_min: lo_rdata_q,
                    band_max: hi_rdata_q, status: ST_OK, last: 1'b1};
        end else if (j_q == top_q) begin
          rv_d = 1'b1; st_d = S_IDLE;
          res_d = '{kind: 1'b1, band_index: 4'd0, band_min: b0lo_q,
                    band_max: hi_rdata_q, status: ST_OUTSIDE, last: 1'b1};
        end else begin
          j_d = j_q + 1'b1; b_raddr = j_d;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign busy_o      = (st_q != S_IDLE);
  assign res_o       = res_q;
  assign res_valid_o = rv_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(MAX_VALUES))
    else $error("store count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start_i && !busy_o && in_i.op == OP_CLEAR) |=> cnt_q == '0 && !rdy_q)
    else $error("clear did not empty the store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (rv_q && res_q.kind == 1'b1) |-> res_q.last)
    else $error("classify answer without last");

endmodule
`default_nettype wire
